// ===== hw/rtl/tsa_pkg.sv =====
package tsa_pkg;

   // Fractional bits of the vertex norms and of the denominator.
   localparam int FRAC = 16;

   // Width of the normalized operands that enter the angle iterations.
   localparam int MANT_W = 60;

   // Datapath widths of the angle iterations.
   localparam int XW = 64;
   localparam int ZW = 33;
   localparam int ITER = 30;

   // Output angle: units of pi/32768, clamped to plus or minus two pi.
   localparam int SA_W = 18;
   localparam int SA_MAX = 65536;
   localparam int SA_SHIFT = 14;

   // Quarter turn in the units of the angle accumulator (pi/2^30).
   localparam int QUARTER = 536870912;

   // Arctangent of 2^-i in units of pi/2^30, rounded to nearest.
   localparam logic [28:0] ATAN_TAB [ITER] = '{
      29'd268435456, 29'd158466703, 29'd83729454, 29'd42502378, 29'd21333666,
      29'd10677233, 29'd5339919, 29'd2670123, 29'd1335082, 29'd667543,
      29'd333772, 29'd166886, 29'd83443, 29'd41722, 29'd20861,
      29'd10430, 29'd5215, 29'd2608, 29'd1304, 29'd652,
      29'd326, 29'd163, 29'd81, 29'd41, 29'd20,
      29'd10, 29'd5, 29'd3, 29'd1, 29'd1
   };

endpackage

// ===== hw/rtl/tsa_delay.sv =====
module tsa_delay #(
   parameter int W = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   output logic [W-1:0] out_data
);

   logic [W-1:0] data_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   if (DEPTH > 1) begin : g_deep
      assign valid_in = {valid_ff[DEPTH-2:0], in_valid};
   end else begin : g_one
      assign valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff[0] <= in_data;
         for (int k = 1; k < DEPTH; k++) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

// ===== hw/rtl/tsa_sqrt.sv =====
module tsa_sqrt #(
   parameter int IW = 32,
   parameter int FB = 16
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [IW-1:0]        value,
   output logic [IW/2+FB-1:0]   root
);

   // One result bit per stage, restoring digit-by-digit on value * 2^(2*FB).
   localparam int RW  = IW / 2 + FB;
   localparam int AW  = IW + 2 * FB;
   localparam int RMW = RW + 3;

   logic [RMW-1:0] rem_ff  [RW];
   logic [RW-1:0]  root_ff [RW];
   logic [AW-1:0]  op_ff   [RW];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [RMW-1:0] rem_prev;
      logic [RW-1:0]  root_prev;
      logic [AW-1:0]  op_prev;
      logic [RMW-1:0] rem_shift;
      logic [RMW-1:0] trial;
      logic [RMW-1:0] rem_in;
      logic [RW-1:0]  root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign op_prev   = {value, {(2 * FB){1'b0}}};
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign op_prev   = op_ff[k-1];
      end

      assign rem_shift = {rem_prev[RMW-3:0], op_prev[AW-1 -: 2]};
      assign trial     = {1'b0, root_prev, 2'b01};

      always_comb begin
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_prev[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_prev[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            op_ff[k]   <= {op_prev[AW-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

// ===== hw/rtl/tsa_front.sv =====
module tsa_front #(
   parameter int CB = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [9*CB-1:0]        verts,
   output logic                   out_valid,
   output logic [2*CB-1:0]        sq [3],
   output logic signed [2*CB:0]   dp [3],
   output logic signed [3*CB:0]   nom
);

   // Vertex pairs of the dot products: r1.r2, r2.r3, r1.r3.
   localparam int PA [3] = '{0, 1, 0};
   localparam int PB [3] = '{1, 2, 2};

   logic signed [CB-1:0] vtx [3][3];

   logic [3:0] valid_ff;

   logic signed [2*CB-1:0] sqp_ff [3][3];
   logic signed [2*CB-1:0] dpp_ff [3][3];
   logic signed [2*CB-1:0] cpa_ff [3];
   logic signed [2*CB-1:0] cpb_ff [3];
   logic signed [CB-1:0]   r1a_ff [3];

   logic [2*CB-1:0]        sq2_ff [3];
   logic signed [2*CB:0]   dp2_ff [3];
   logic signed [2*CB:0]   cr_ff  [3];
   logic signed [CB-1:0]   r1b_ff [3];

   logic [2*CB-1:0]        sq3_ff [3];
   logic signed [2*CB:0]   dp3_ff [3];
   logic signed [3*CB:0]   nomp_ff [3];

   logic [2*CB-1:0]        sq4_ff [3];
   logic signed [2*CB:0]   dp4_ff [3];
   logic signed [3*CB:0]   nom_ff;

   logic signed [2*CB+1:0] sq_sum [3];
   logic signed [2*CB+1:0] dp_sum [3];

   for (genvar i = 0; i < 3; i++) begin : g_vtx
      for (genvar j = 0; j < 3; j++) begin : g_axis
         assign vtx[i][j] = verts[(3 * i + j) * CB +: CB];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_sum[i] = {{2{sqp_ff[i][0][2*CB-1]}}, sqp_ff[i][0]}
                   + {{2{sqp_ff[i][1][2*CB-1]}}, sqp_ff[i][1]}
                   + {{2{sqp_ff[i][2][2*CB-1]}}, sqp_ff[i][2]};
         dp_sum[i] = {{2{dpp_ff[i][0][2*CB-1]}}, dpp_ff[i][0]}
                   + {{2{dpp_ff[i][1][2*CB-1]}}, dpp_ff[i][1]}
                   + {{2{dpp_ff[i][2][2*CB-1]}}, dpp_ff[i][2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // Products of squares, dot products and cross product terms.
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               sqp_ff[i][j] <= vtx[i][j] * vtx[i][j];
               dpp_ff[i][j] <= vtx[PA[i]][j] * vtx[PB[i]][j];
            end
            cpa_ff[i] <= vtx[1][(i + 1) % 3] * vtx[2][(i + 2) % 3];
            cpb_ff[i] <= vtx[1][(i + 2) % 3] * vtx[2][(i + 1) % 3];
            r1a_ff[i] <= vtx[0][i];
         end

         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= sq_sum[i][2*CB-1:0];
            dp2_ff[i] <= dp_sum[i][2*CB:0];
            cr_ff[i]  <= {cpa_ff[i][2*CB-1], cpa_ff[i]} - {cpb_ff[i][2*CB-1], cpb_ff[i]};
            r1b_ff[i] <= r1a_ff[i];
         end

         for (int i = 0; i < 3; i++) begin
            sq3_ff[i]  <= sq2_ff[i];
            dp3_ff[i]  <= dp2_ff[i];
            nomp_ff[i] <= cr_ff[i] * r1b_ff[i];
         end

         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= sq3_ff[i];
            dp4_ff[i] <= dp3_ff[i];
         end
         nom_ff <= nomp_ff[0] + nomp_ff[1] + nomp_ff[2];
      end
   end

   assign out_valid = valid_ff[3];
   assign sq  = sq4_ff;
   assign dp  = dp4_ff;
   assign nom = nom_ff;

endmodule

// ===== hw/rtl/tsa_angle.sv =====
module tsa_angle #(
   parameter int CB = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic signed [3*CB:0]              nom,
   input  logic signed [3*CB+18:0]           den,
   output logic                              out_valid,
   output logic signed [tsa_pkg::SA_W-1:0]   solid_angle,
   output logic                              on_plane
);

   localparam int NW   = 3 * CB + 1;
   localparam int DW   = 3 * CB + 19;
   localparam int MW   = 3 * CB + 18;
   localparam int MANT = tsa_pkg::MANT_W;
   localparam int PW   = (MW > MANT) ? MW : MANT;
   localparam int NSH  = 7;
   localparam int XW   = tsa_pkg::XW;
   localparam int ZW   = tsa_pkg::ZW;
   localparam int ITER = tsa_pkg::ITER;
   localparam int FRAC = tsa_pkg::FRAC;

   localparam logic signed [ZW-1:0] ROUND  = ZW'(1 << (tsa_pkg::SA_SHIFT - 1));
   localparam logic signed [ZW-1:0] SA_HI  = ZW'(tsa_pkg::SA_MAX);
   localparam logic signed [ZW-1:0] SA_LO  = -SA_HI;
   localparam logic signed [ZW-1:0] QTURN  = ZW'(tsa_pkg::QUARTER);

   typedef struct packed {
      logic valid;
      logic zero;
      logic onp;
      logic nneg;
      logic dneg;
   } flag_type;

   // Magnitude stage and leading-bit normalization, one shift size per stage.
   flag_type        flag_ff [NSH+1];
   logic [PW-1:0]   a_ff    [NSH+1];
   logic [PW-1:0]   b_ff    [NSH+1];

   flag_type        flag_in;
   logic [MW:0]     nom_ext;
   logic [MW:0]     nom_abs;
   logic [DW-1:0]   den_abs;

   assign nom_ext = {{(MW - NW + 1){nom[NW-1]}}, nom};
   assign nom_abs = nom[NW-1] ? (~nom_ext + 1'b1) : nom_ext;
   assign den_abs = den[DW-1] ? (~den + 1'b1) : den;

   always_comb begin
      flag_in.valid = in_valid;
      flag_in.zero  = (nom == '0);
      flag_in.onp   = (nom == '0) && (den[DW-1] || (den == '0));
      flag_in.nneg  = nom[NW-1];
      flag_in.dneg  = den[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff[0] <= '0;
      end else if (advance) begin
         flag_ff[0] <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff[0] <= PW'({nom_abs[MW-FRAC-1:0], {FRAC{1'b0}}});
         b_ff[0] <= PW'(den_abs[MW-1:0]);
      end
   end

   for (genvar k = 0; k < NSH; k++) begin : g_norm
      localparam int S = 1 << (NSH - 1 - k);
      logic [PW-1:0] a_in;
      logic [PW-1:0] b_in;

      if (S < PW) begin : g_shift
         logic [PW-1:0] both;
         logic          shift;
         assign both  = a_ff[k] | b_ff[k];
         assign shift = ~|both[PW-1 -: S];
         assign a_in  = shift ? (a_ff[k] << S) : a_ff[k];
         assign b_in  = shift ? (b_ff[k] << S) : b_ff[k];
      end else begin : g_pass
         assign a_in = a_ff[k];
         assign b_in = b_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            flag_ff[k+1] <= '0;
         end else if (advance) begin
            flag_ff[k+1] <= flag_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            a_ff[k+1] <= a_in;
            b_ff[k+1] <= b_in;
         end
      end
   end

   // Signed operands and the quarter-turn pre-rotation for a negative den.
   flag_type              cflag_ff [ITER+1];
   logic signed [XW-1:0]  x_ff     [ITER+1];
   logic signed [XW-1:0]  y_ff     [ITER+1];
   logic signed [ZW-1:0]  z_ff     [ITER+1];

   logic signed [XW-1:0]  y0;
   logic signed [XW-1:0]  x0;
   logic signed [XW-1:0]  x_in;
   logic signed [XW-1:0]  y_in;
   logic signed [ZW-1:0]  z_in;
   logic [XW-1:0]         ymag;
   logic [XW-1:0]         xmag;

   assign ymag = XW'(a_ff[NSH][PW-1 -: MANT]);
   assign xmag = XW'(b_ff[NSH][PW-1 -: MANT]);
   assign y0   = flag_ff[NSH].nneg ? -$signed(ymag) : $signed(ymag);
   assign x0   = flag_ff[NSH].dneg ? -$signed(xmag) : $signed(xmag);

   always_comb begin
      x_in = x0;
      y_in = y0;
      z_in = '0;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            x_in = y0;
            y_in = -x0;
            z_in = QTURN;
         end else begin
            x_in = -y0;
            y_in = x0;
            z_in = -QTURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cflag_ff[0] <= '0;
      end else if (advance) begin
         cflag_ff[0] <= flag_ff[NSH];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         z_ff[0] <= z_in;
      end
   end

   // Vectoring iterations, one per stage.
   for (genvar i = 0; i < ITER; i++) begin : g_iter
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [ZW-1:0] step;

      assign dx   = y_ff[i] >>> i;
      assign dy   = x_ff[i] >>> i;
      assign step = $signed(ZW'(tsa_pkg::ATAN_TAB[i]));

      always_ff @(posedge clock) begin
         if (reset) begin
            cflag_ff[i+1] <= '0;
         end else if (advance) begin
            cflag_ff[i+1] <= cflag_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + step;
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - step;
            end
         end
      end
   end

   // Rounding to pi/32768, sign flip and clamp, or zero when nom is zero.
   logic signed [ZW-1:0]            z_round;
   logic signed [ZW-1:0]            sa_full;
   logic signed [tsa_pkg::SA_W-1:0] sa_in;
   logic signed [tsa_pkg::SA_W-1:0] sa_ff;
   logic                            onp_ff;
   logic                            valid_ff;

   assign z_round = (z_ff[ITER] + ROUND) >>> tsa_pkg::SA_SHIFT;
   assign sa_full = -z_round;

   always_comb begin
      if (cflag_ff[ITER].zero) begin
         sa_in = '0;
      end else if (sa_full > SA_HI) begin
         sa_in = SA_HI[tsa_pkg::SA_W-1:0];
      end else if (sa_full < SA_LO) begin
         sa_in = SA_LO[tsa_pkg::SA_W-1:0];
      end else begin
         sa_in = sa_full[tsa_pkg::SA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= cflag_ff[ITER].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sa_ff  <= sa_in;
         onp_ff <= cflag_ff[ITER].onp;
      end
   end

   assign out_valid   = valid_ff;
   assign solid_angle = sa_ff;
   assign on_plane    = onp_ff;

endmodule

// ===== hw/rtl/triangle_solid_angle.sv =====
// Signed solid angle of a triangle seen from the origin, by the Van Oosterom-Strackee
// formula -2*atan2(r1.(r2 x r3), den), in units of pi/32768 within two LSB. The block
// takes one word per cycle and returns one word per input word, in order; latency is
// set mostly by the bit-per-stage norm square roots and the 30-stage arctangent
// unit. While a result word waits with rsp_tready low the whole pipeline holds.
// When the triple product is zero the angle is zero, and tuser marks the origin as
// lying on the triangle when den is not positive.
module triangle_solid_angle #(
   parameter int COORD_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z from bit 0 up.
   input  logic [((9 * COORD_BITS + 7) / 8) * 8-1:0] req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // solid_angle from bit 0 up.
   output logic [23:0]                               rsp_tdata,
   // on_plane_flag.
   output logic [0:0]                                rsp_tuser
);

   localparam int CB   = COORD_BITS;
   localparam int FRAC = tsa_pkg::FRAC;
   localparam int RW   = CB + FRAC;
   localparam int NW   = 3 * CB + 1;
   localparam int DPW  = 2 * CB + 1;
   localparam int TW   = 3 * CB + 18;
   localparam int DW   = 3 * CB + 19;
   localparam int P12W = 2 * CB + FRAC;
   localparam int QW   = 3 * CB + FRAC;
   localparam int LW   = 3 * DPW + NW;

   logic advance;

   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   logic                    front_valid;
   logic [2*CB-1:0]         sq  [3];
   logic signed [2*CB:0]    dp  [3];
   logic signed [3*CB:0]    nom;

   tsa_front #(.CB(CB)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .verts     (req_tdata[9*CB-1:0]),
      .out_valid (front_valid),
      .sq        (sq),
      .dp        (dp),
      .nom       (nom)
   );

   logic [RW-1:0] norm [3];

   for (genvar i = 0; i < 3; i++) begin : g_norm
      tsa_sqrt #(.IW(2 * CB), .FB(FRAC)) u_sqrt (
         .clock   (clock),
         .advance (advance),
         .value   (sq[i]),
         .root    (norm[i])
      );
   end

   logic          side_valid;
   logic [LW-1:0] side_data;

   tsa_delay #(.W(LW), .DEPTH(RW)) u_side (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_data   ({nom, dp[2], dp[1], dp[0]}),
      .out_valid (side_valid),
      .out_data  (side_data)
   );

   logic signed [DPW-1:0] dpd [3];
   logic signed [NW-1:0]  nomd;

   for (genvar i = 0; i < 3; i++) begin : g_dp
      assign dpd[i] = side_data[i * DPW +: DPW];
   end
   assign nomd = side_data[3 * DPW +: NW];

   // Denominator, four stages with the wide products split on the norm halves.
   logic [3:0]             vd_ff;
   logic [RW+FRAC-1:0]     ma_ff;
   logic [2*RW-1:0]        mb_ff;
   logic signed [TW-1:0]   t_ff [3];
   logic [RW-1:0]          n3a_ff;
   logic [RW-1:0]          n3b_ff;
   logic signed [NW-1:0]   nom1_ff;
   logic signed [NW-1:0]   nom2_ff;
   logic signed [NW-1:0]   nom3_ff;
   logic signed [NW-1:0]   nom4_ff;
   logic [P12W-1:0]        p12_ff;
   logic signed [DW-1:0]   ts2_ff;
   logic signed [DW-1:0]   ts3_ff;
   logic [P12W+FRAC-1:0]   me_ff;
   logic [QW-1:0]          mf_ff;
   logic signed [DW-1:0]   den_ff;

   logic [2*RW-1:0]        p12_sum;
   logic [QW+FRAC-1:0]     q_sum;

   assign p12_sum = {mb_ff[RW+CB-1:0], {FRAC{1'b0}}} + (2 * RW)'(ma_ff);
   assign q_sum   = {mf_ff, {FRAC{1'b0}}} + (QW + FRAC)'(me_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else if (advance) begin
         vd_ff <= {vd_ff[2:0], side_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ma_ff   <= (RW + FRAC)'(norm[0]) * (RW + FRAC)'(norm[1][FRAC-1:0]);
         mb_ff   <= (2 * RW)'(norm[0]) * (2 * RW)'(norm[1][RW-1:FRAC]);
         t_ff[0] <= dpd[0] * $signed({1'b0, norm[2]});
         t_ff[1] <= dpd[1] * $signed({1'b0, norm[0]});
         t_ff[2] <= dpd[2] * $signed({1'b0, norm[1]});
         n3a_ff  <= norm[2];
         nom1_ff <= nomd;

         p12_ff  <= p12_sum[2*RW-1:FRAC];
         ts2_ff  <= DW'(t_ff[0]) + DW'(t_ff[1]) + DW'(t_ff[2]);
         n3b_ff  <= n3a_ff;
         nom2_ff <= nom1_ff;

         me_ff   <= (P12W + FRAC)'(p12_ff) * (P12W + FRAC)'(n3b_ff[FRAC-1:0]);
         mf_ff   <= QW'(p12_ff) * QW'(n3b_ff[RW-1:FRAC]);
         ts3_ff  <= ts2_ff;
         nom3_ff <= nom2_ff;

         den_ff  <= $signed(DW'(q_sum[QW+FRAC-1:FRAC])) + ts3_ff;
         nom4_ff <= nom3_ff;
      end
   end

   logic                               ang_valid;
   logic signed [tsa_pkg::SA_W-1:0]    solid_angle;
   logic                               on_plane_flag;

   tsa_angle #(.CB(CB)) u_angle (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (vd_ff[3]),
      .nom         (nom4_ff),
      .den         (den_ff),
      .out_valid   (ang_valid),
      .solid_angle (solid_angle),
      .on_plane    (on_plane_flag)
   );

   assign rsp_tvalid = ang_valid;
   assign rsp_tdata  = {{(24 - tsa_pkg::SA_W){1'b0}}, solid_angle};
   assign rsp_tuser  = on_plane_flag;

endmodule
